@@ rtl/core/midpoint_ellipse_rasterizer_assert.svh @@
// Assertion macros used by the checker module of the ellipse rasteriser.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mer_pkg.sv @@
package mer_pkg;

   localparam int COORD_WIDTH = 10;
   localparam int AXIS_W      = COORD_WIDTH - 1;
   localparam int WALK_W      = AXIS_W + 2;
   localparam int SQ_W        = 2 * AXIS_W;
   localparam int PIX_W       = COORD_WIDTH + 2;
   localparam int DEC_W       = 4 * COORD_WIDTH + 2;
   localparam int MUL_A_W     = 2 * WALK_W;
   localparam int MUL_B_W     = SQ_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   typedef logic [1:0] reg_index_type;
   typedef logic signed [PIX_W-1:0] pixel_type;

   localparam reg_index_type REG_CENTER_X    = 2'd0;
   localparam reg_index_type REG_CENTER_Y    = 2'd1;
   localparam reg_index_type REG_SEMI_AXIS_X = 2'd2;
   localparam reg_index_type REG_SEMI_AXIS_Y = 2'd3;

   localparam logic [COORD_WIDTH-1:0] CENTER_X_RESET    = COORD_WIDTH'(250);
   localparam logic [COORD_WIDTH-1:0] CENTER_Y_RESET    = COORD_WIDTH'(250);
   localparam logic [AXIS_W-1:0]      SEMI_AXIS_X_RESET = AXIS_W'(150);
   localparam logic [AXIS_W-1:0]      SEMI_AXIS_Y_RESET = AXIS_W'(100);

endpackage

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse rasteriser. Each request either restarts the walk at (0, b)
// (restart high) or advances it by one position, and a plotting request returns
// four responses, the symmetric pixels about the centre, with last_of_step on
// the fourth and final_step on all four when the row y = 0 is plotted. Before
// any restart, and after the arc has ended, a request returns nothing. All
// products go through one shared registered multiplier, one per cycle, under
// a small sequencer, and the block holds req_ready low until the four
// responses have been taken. A step walks A2, B2, B2W, AY, BX, DECIDE, STEP,
// EMIT; a restart adds LOAD, the move to region 2 adds Q, R, S, T and R2INIT,
// and a stall holds EMIT. The user must write configuration registers
// through the csr_ port only while idle; the block does not enforce it.
module midpoint_ellipse_rasterizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mer_pkg::pixel_type                    rsp_pixel_x,
   output mer_pkg::pixel_type                    rsp_pixel_y,
   output logic                                  rsp_last_of_step,
   output logic                                  rsp_final_step,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [mer_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [mer_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_A2      = 4'd1;
   localparam logic [3:0] ST_B2      = 4'd2;
   localparam logic [3:0] ST_B2W     = 4'd3;
   localparam logic [3:0] ST_LOAD    = 4'd4;
   localparam logic [3:0] ST_AY      = 4'd5;
   localparam logic [3:0] ST_BX      = 4'd6;
   localparam logic [3:0] ST_DECIDE  = 4'd7;
   localparam logic [3:0] ST_Q       = 4'd8;
   localparam logic [3:0] ST_R       = 4'd9;
   localparam logic [3:0] ST_S       = 4'd10;
   localparam logic [3:0] ST_T       = 4'd11;
   localparam logic [3:0] ST_R2INIT  = 4'd12;
   localparam logic [3:0] ST_STEP    = 4'd13;
   localparam logic [3:0] ST_EMIT    = 4'd14;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_R1   = 2'd1;
   localparam logic [1:0] PH_R2   = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [1:0] BEAT_LAST = 2'd3;

   logic [mer_pkg::COORD_WIDTH-1:0]  center_x_ff, center_x_in;
   logic [mer_pkg::COORD_WIDTH-1:0]  center_y_ff, center_y_in;
   logic [mer_pkg::AXIS_W-1:0]       axis_x_ff, axis_x_in;
   logic [mer_pkg::AXIS_W-1:0]       axis_y_ff, axis_y_in;

   logic [3:0]                        state_ff, state_in;
   logic [1:0]                        phase_ff, phase_in;
   logic                              restart_ff, restart_in;
   logic [1:0]                        beat_ff, beat_in;

   logic signed [mer_pkg::WALK_W-1:0] x_ff, x_in;
   logic signed [mer_pkg::WALK_W-1:0] y_ff, y_in;
   logic signed [mer_pkg::DEC_W-1:0]  dec_ff, dec_in;
   logic [mer_pkg::SQ_W-1:0]          a2_ff, a2_in;
   logic [mer_pkg::SQ_W-1:0]          b2_ff, b2_in;
   logic signed [mer_pkg::PROD_W-1:0] ay_ff, ay_in;
   logic signed [mer_pkg::PROD_W-1:0] bx_ff, bx_in;
   logic signed [mer_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [mer_pkg::WALK_W-1:0] emit_x_ff, emit_x_in;
   logic signed [mer_pkg::WALK_W-1:0] emit_y_ff, emit_y_in;
   logic                              final_ff, final_in;

   logic signed [mer_pkg::MUL_A_W-1:0] mul_a;
   logic signed [mer_pkg::MUL_B_W-1:0] mul_b;
   logic signed [mer_pkg::WALK_W:0]    twox1;
   logic signed [mer_pkg::WALK_W:0]    ym1;
   logic signed [mer_pkg::WALK_W-1:0]  x_inc;
   logic signed [mer_pkg::WALK_W-1:0]  y_dec;

   logic signed [mer_pkg::DEC_W-1:0] a2_ext, b2_ext, ay_ext, bx_ext, prod_ext;
   logic signed [mer_pkg::DEC_W-1:0] t8a2, t4a2, t8b2, t4b2, t8ay, t8bx;

   mer_pkg::reg_index_type csr_index;
   logic                   csr_write;
   mer_pkg::pixel_type     off_x, off_y;

   assign csr_index = csr_paddr[mer_pkg::CSR_ADDR_W-1:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         mer_pkg::REG_CENTER_X:    csr_prdata = mer_pkg::CSR_DATA_W'(center_x_ff);
         mer_pkg::REG_CENTER_Y:    csr_prdata = mer_pkg::CSR_DATA_W'(center_y_ff);
         mer_pkg::REG_SEMI_AXIS_X: csr_prdata = mer_pkg::CSR_DATA_W'(axis_x_ff);
         mer_pkg::REG_SEMI_AXIS_Y: csr_prdata = mer_pkg::CSR_DATA_W'(axis_y_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign twox1 = signed'({x_ff, 1'b1});
   assign ym1   = (mer_pkg::WALK_W+1)'(y_ff) - (mer_pkg::WALK_W+1)'(1);
   assign x_inc = x_ff + mer_pkg::WALK_W'(1);
   assign y_dec = y_ff - mer_pkg::WALK_W'(1);

   // The shared multiplier: operands are chosen by the sequencer state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_A2: begin
            mul_a = mer_pkg::MUL_A_W'(axis_x_ff);
            mul_b = mer_pkg::MUL_B_W'(axis_x_ff);
         end
         ST_B2: begin
            mul_a = mer_pkg::MUL_A_W'(axis_y_ff);
            mul_b = mer_pkg::MUL_B_W'(axis_y_ff);
         end
         ST_B2W: begin
            mul_a = mer_pkg::MUL_A_W'(a2_ff);
            mul_b = mer_pkg::MUL_B_W'(axis_y_ff);
         end
         ST_AY: begin
            mul_a = mer_pkg::MUL_A_W'(a2_ff);
            mul_b = mer_pkg::MUL_B_W'(y_ff);
         end
         ST_BX: begin
            mul_a = mer_pkg::MUL_A_W'(b2_ff);
            mul_b = mer_pkg::MUL_B_W'(x_ff);
         end
         ST_DECIDE: begin
            mul_a = mer_pkg::MUL_A_W'(twox1);
            mul_b = mer_pkg::MUL_B_W'(twox1);
         end
         ST_Q: begin
            mul_a = signed'(prod_ff[mer_pkg::MUL_A_W-1:0]);
            mul_b = mer_pkg::MUL_B_W'(b2_ff);
         end
         ST_R: begin
            mul_a = mer_pkg::MUL_A_W'(ym1);
            mul_b = mer_pkg::MUL_B_W'(ym1);
         end
         ST_S: begin
            mul_a = signed'(prod_ff[mer_pkg::MUL_A_W-1:0]);
            mul_b = mer_pkg::MUL_B_W'(a2_ff);
         end
         ST_T: begin
            mul_a = mer_pkg::MUL_A_W'(a2_ff);
            mul_b = mer_pkg::MUL_B_W'(b2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mer_pkg::PROD_W'(mul_a) * mer_pkg::PROD_W'(mul_b);
   end

   assign a2_ext   = mer_pkg::DEC_W'(signed'({1'b0, a2_ff}));
   assign b2_ext   = mer_pkg::DEC_W'(signed'({1'b0, b2_ff}));
   assign ay_ext   = mer_pkg::DEC_W'(ay_ff);
   assign bx_ext   = mer_pkg::DEC_W'(bx_ff);
   assign prod_ext = mer_pkg::DEC_W'(prod_ff);
   assign t8a2 = a2_ext <<< 3;
   assign t4a2 = a2_ext <<< 2;
   assign t8b2 = b2_ext <<< 3;
   assign t4b2 = b2_ext <<< 2;
   assign t8ay = ay_ext <<< 3;
   assign t8bx = bx_ext <<< 3;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      axis_x_in   = axis_x_ff;
      axis_y_in   = axis_y_ff;
      state_in    = state_ff;
      phase_in    = phase_ff;
      restart_in  = restart_ff;
      beat_in     = beat_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      dec_in      = dec_ff;
      a2_in       = a2_ff;
      b2_in       = b2_ff;
      ay_in       = ay_ff;
      bx_in       = bx_ff;
      emit_x_in   = emit_x_ff;
      emit_y_in   = emit_y_ff;
      final_in    = final_ff;
      req_ready   = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            mer_pkg::REG_CENTER_X:    center_x_in = csr_pwdata[mer_pkg::COORD_WIDTH-1:0];
            mer_pkg::REG_CENTER_Y:    center_y_in = csr_pwdata[mer_pkg::COORD_WIDTH-1:0];
            mer_pkg::REG_SEMI_AXIS_X: axis_x_in = csr_pwdata[mer_pkg::AXIS_W-1:0];
            mer_pkg::REG_SEMI_AXIS_Y: axis_y_in = csr_pwdata[mer_pkg::AXIS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               restart_in = req_restart;
               if (req_restart || phase_ff == PH_R1 || phase_ff == PH_R2) begin
                  state_in = ST_A2;
               end
            end
         end
         ST_A2: begin
            state_in = ST_B2;
         end
         ST_B2: begin
            a2_in    = prod_ff[mer_pkg::SQ_W-1:0];
            state_in = ST_B2W;
         end
         ST_B2W: begin
            b2_in    = prod_ff[mer_pkg::SQ_W-1:0];
            state_in = restart_ff ? ST_LOAD : ST_AY;
         end
         ST_LOAD: begin
            dec_in   = t4b2 - (prod_ext <<< 2) + a2_ext;
            x_in     = '0;
            y_in     = mer_pkg::WALK_W'(axis_y_ff);
            phase_in = PH_R1;
            state_in = ST_AY;
         end
         ST_AY: begin
            state_in = ST_BX;
         end
         ST_BX: begin
            ay_in    = prod_ff;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            bx_in = prod_ff;
            if (phase_ff == PH_R1 && !(ay_ff > prod_ff)) begin
               state_in = ST_Q;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_Q: begin
            state_in = ST_R;
         end
         ST_R: begin
            dec_in   = prod_ext;
            state_in = ST_S;
         end
         ST_S: begin
            state_in = ST_T;
         end
         ST_T: begin
            dec_in   = dec_ff + (prod_ext <<< 2);
            state_in = ST_R2INIT;
         end
         ST_R2INIT: begin
            dec_in   = dec_ff - (prod_ext <<< 2);
            phase_in = PH_R2;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            emit_x_in = x_ff;
            emit_y_in = y_ff;
            final_in  = (y_ff == '0);
            beat_in   = '0;
            state_in  = ST_EMIT;
            if (phase_ff == PH_R1) begin
               x_in = x_inc;
               if (dec_ff[mer_pkg::DEC_W-1]) begin
                  dec_in = dec_ff + t8bx + t8b2 + t4b2;
               end else begin
                  y_in   = y_dec;
                  dec_in = dec_ff + t8bx + t8b2 + t4b2 - t8ay + t8a2;
               end
            end else if (y_ff[mer_pkg::WALK_W-1]) begin
               phase_in = PH_DONE;
               state_in = ST_IDLE;
            end else begin
               y_in = y_dec;
               if (!dec_ff[mer_pkg::DEC_W-1] && (dec_ff != '0)) begin
                  dec_in = dec_ff + t8a2 + t4a2 - t8ay;
               end else begin
                  x_in   = x_inc;
                  dec_in = dec_ff + t8bx + t8b2 - t8ay + t8a2 + t4a2;
               end
               if (y_dec[mer_pkg::WALK_W-1]) begin
                  phase_in = PH_DONE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               beat_in = beat_ff + 2'd1;
               if (beat_ff == BEAT_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= mer_pkg::CENTER_X_RESET;
         center_y_ff <= mer_pkg::CENTER_Y_RESET;
         axis_x_ff   <= mer_pkg::SEMI_AXIS_X_RESET;
         axis_y_ff   <= mer_pkg::SEMI_AXIS_Y_RESET;
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_IDLE;
         restart_ff  <= 1'b0;
         beat_ff     <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         dec_ff      <= '0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         axis_x_ff   <= axis_x_in;
         axis_y_ff   <= axis_y_in;
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         restart_ff  <= restart_in;
         beat_ff     <= beat_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         dec_ff      <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      a2_ff     <= a2_in;
      b2_ff     <= b2_in;
      ay_ff     <= ay_in;
      bx_ff     <= bx_in;
      prod_ff   <= prod_in;
      emit_x_ff <= emit_x_in;
      emit_y_ff <= emit_y_in;
      final_ff  <= final_in;
   end

   // The beat counter picks the quadrant: bit 0 mirrors x, bit 1 mirrors y.
   assign off_x = mer_pkg::PIX_W'(emit_x_ff);
   assign off_y = mer_pkg::PIX_W'(emit_y_ff);

   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_pixel_x      = signed'(mer_pkg::PIX_W'(center_x_ff))
                             + (beat_ff[0] ? -off_x : off_x);
   assign rsp_pixel_y      = signed'(mer_pkg::PIX_W'(center_y_ff))
                             + (beat_ff[1] ? -off_y : off_y);
   assign rsp_last_of_step = (beat_ff == BEAT_LAST);
   assign rsp_final_step   = final_ff;

endmodule

@@ rtl/core/mer_checker.sv @@
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mer_pkg::pixel_type rsp_pixel_x,
   input mer_pkg::pixel_type rsp_pixel_y,
   input logic               rsp_last_of_step,
   input logic               rsp_final_step
);

   // A new request is never taken while a response of the previous one is pending.
   `MER_ASSERT_NOW(a_no_request_while_busy, clock, reset, rsp_valid, !req_ready, "request taken while responses pending")

   // The fourth response closes the step.
   `MER_ASSERT_NEXT(a_four_per_step, clock, reset, rsp_valid && rsp_ready && rsp_last_of_step, !rsp_valid, "response after the last of a step")

   // The responses of one step follow without a gap and share final_step.
   `MER_ASSERT_NEXT(a_step_contiguous, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_step, rsp_valid && $stable(rsp_final_step), "step broken or final_step changed")

   // A stalled response holds its pixel.
   `MER_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y), "stalled response changed")

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
